>>> src/tvss_pkg.sv
// ----------------------------------------------------------------------------
// tvss_pkg
// Shared constants, codes and types of the timed valve step sequencer.
// ----------------------------------------------------------------------------
package tvss_pkg;

    localparam int NUM_VALVES = 4;
    localparam int SEQ_STEPS  = 16;

    localparam int STEP_W     = (SEQ_STEPS > 1) ? $clog2(SEQ_STEPS) : 1;
    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int TARGET_W   = 3;
    localparam int WAIT_W     = 16;
    localparam int ELAPSED_W  = 17;
    localparam int VNUM_W     = 2;
    localparam int CUR_STEP_W = 4;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_LOAD  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic                en;
        logic [STEP_W-1:0]   addr;
        logic [TARGET_W-1:0] target;
        logic                open;
        logic [WAIT_W-1:0]   wait_ms;
    } t_load;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                open;
    } t_step_entry;

    typedef struct packed {
        logic [CUR_STEP_W-1:0] current_step;
        logic                  arm_active;
        logic                  start_other_arm;
        logic                  valve_level;
        logic [VNUM_W-1:0]     valve_number;
        logic                  valve_write;
    } t_result;

endpackage

>>> src/timed_valve_step_sequencer.sv
// ----------------------------------------------------------------------------
// timed_valve_step_sequencer
// One arm of a valve controller that steps through a loaded table of timed
// valve actions.
//
// Channel | Direction | Content
// s_axis  | in        | tuser opcode; tdata demand, load index/target/open/wait
// m_axis  | out       | tdata valve write/number/level, start other arm, status
//
// Every transfer in gives exactly one transfer out, registered and offered in the cycle after it is accepted.
// A new transfer is taken every cycle while the result register drains.
// The table read, tick compare and step update happen in the same cycle.
// Reset clears the step pointer, elapsed count and run flag; the table is not
// cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module timed_valve_step_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] opcode
    input  logic [tvss_pkg::OPCODE_W-1:0]     s_axis_tuser,
    // [0] oxygen_demand, [4:1] entry_index, [7:5] entry_target,
    // [8] entry_open, [24:9] entry_wait_ms, [31:25] zero
    input  logic [tvss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] valve_write, [2:1] valve_number, [3] valve_level,
    // [4] start_other_arm, [5] arm_active, [9:6] current_step, [15:10] zero
    output logic [tvss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic                            accept;
    logic [tvss_pkg::INDEX_W-1:0]    entry_index;
    tvss_pkg::t_load                 load;
    logic [tvss_pkg::STEP_W-1:0]     wait_addr;
    logic [tvss_pkg::STEP_W-1:0]     run_addr;
    logic [tvss_pkg::WAIT_W-1:0]     wait_ms;
    tvss_pkg::t_step_entry           entry;
    tvss_pkg::t_result               result;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign entry_index = s_axis_tdata[4:1];

    always_comb begin
        load.en      = accept && (s_axis_tuser == tvss_pkg::OP_LOAD) &&
                       ({1'b0, entry_index} < 5'(tvss_pkg::SEQ_STEPS));
        load.addr    = tvss_pkg::STEP_W'(entry_index);
        load.target  = s_axis_tdata[7:5];
        load.open    = s_axis_tdata[8];
        load.wait_ms = s_axis_tdata[24:9];
    end

    tvss_table u_table (
        .i_clk       (i_clk),
        .i_load      (load),
        .i_wait_addr (wait_addr),
        .i_run_addr  (run_addr),
        .o_wait_ms   (wait_ms),
        .o_entry     (entry)
    );

    tvss_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_opcode        (s_axis_tuser),
        .i_oxygen_demand (s_axis_tdata[0]),
        .i_wait_ms       (wait_ms),
        .i_entry         (entry),
        .o_wait_addr     (wait_addr),
        .o_run_addr      (run_addr),
        .o_result        (result)
    );

    tvss_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (result),
        .o_can_load (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

>>> src/tvss_table.sv
// ----------------------------------------------------------------------------
// tvss_table
// Step table: wait times read at the current step, targets at the step run.
// ----------------------------------------------------------------------------
module tvss_table (
    input  logic                          i_clk,
    input  tvss_pkg::t_load               i_load,
    input  logic [tvss_pkg::STEP_W-1:0]   i_wait_addr,
    input  logic [tvss_pkg::STEP_W-1:0]   i_run_addr,
    output logic [tvss_pkg::WAIT_W-1:0]   o_wait_ms,
    output tvss_pkg::t_step_entry         o_entry
);

    logic [tvss_pkg::WAIT_W-1:0] r_wait  [tvss_pkg::SEQ_STEPS];
    tvss_pkg::t_step_entry       r_entry [tvss_pkg::SEQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_load.en) begin
            r_wait[i_load.addr]         <= i_load.wait_ms;
            r_entry[i_load.addr].target <= i_load.target;
            r_entry[i_load.addr].open   <= i_load.open;
        end
    end

    assign o_wait_ms = r_wait[i_wait_addr];
    assign o_entry   = r_entry[i_run_addr];

endmodule

>>> src/tvss_ctrl.sv
// ----------------------------------------------------------------------------
// tvss_ctrl
// Step pointer, elapsed counter and run flag, with the decode of a run step.
// ----------------------------------------------------------------------------
module tvss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [tvss_pkg::OPCODE_W-1:0] i_opcode,
    input  logic                          i_oxygen_demand,
    input  logic [tvss_pkg::WAIT_W-1:0]   i_wait_ms,
    input  tvss_pkg::t_step_entry         i_entry,
    output logic [tvss_pkg::STEP_W-1:0]   o_wait_addr,
    output logic [tvss_pkg::STEP_W-1:0]   o_run_addr,
    output tvss_pkg::t_result             o_result
);

    logic [tvss_pkg::STEP_W-1:0]    r_ptr;
    logic [tvss_pkg::STEP_W-1:0]    n_ptr;
    logic [tvss_pkg::ELAPSED_W-1:0] r_elapsed;
    logic [tvss_pkg::ELAPSED_W-1:0] n_elapsed;
    logic                           r_running;
    logic                           n_running;
    logic [tvss_pkg::ELAPSED_W-1:0] elapsed_inc;
    logic                           do_run;

    assign elapsed_inc = (r_elapsed == tvss_pkg::ELAPSED_MAX) ?
                         r_elapsed : r_elapsed + tvss_pkg::ELAPSED_W'(1);
    assign o_wait_addr = r_ptr;

    always_comb begin
        n_ptr      = r_ptr;
        n_elapsed  = r_elapsed;
        n_running  = r_running;
        do_run     = 1'b0;
        o_run_addr = '0;
        case (i_opcode)
            tvss_pkg::OP_TICK: begin
                if (r_running) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc > {1'b0, i_wait_ms}) begin
                        if (r_ptr == tvss_pkg::STEP_W'(tvss_pkg::SEQ_STEPS - 1)) begin
                            n_ptr     = '0;
                            n_elapsed = '0;
                            n_running = i_oxygen_demand;
                            do_run    = i_oxygen_demand;
                        end else begin
                            n_ptr      = r_ptr + tvss_pkg::STEP_W'(1);
                            o_run_addr = r_ptr + tvss_pkg::STEP_W'(1);
                            do_run     = 1'b1;
                        end
                    end
                end
            end
            tvss_pkg::OP_START: begin
                n_ptr     = '0;
                n_elapsed = '0;
                n_running = i_oxygen_demand;
                do_run    = i_oxygen_demand;
            end
            default: begin
            end
        endcase
        if (do_run) begin
            n_elapsed = '0;
        end
    end

    always_comb begin
        o_result                 = '0;
        o_result.arm_active      = n_running;
        o_result.current_step    = tvss_pkg::CUR_STEP_W'(n_ptr);
        if (do_run) begin
            if (i_entry.target == tvss_pkg::TARGET_W'(tvss_pkg::NUM_VALVES)) begin
                o_result.start_other_arm = 1'b1;
            end else if (i_entry.target < tvss_pkg::TARGET_W'(tvss_pkg::NUM_VALVES)) begin
                o_result.valve_write  = 1'b1;
                o_result.valve_number = i_entry.target[tvss_pkg::VNUM_W-1:0];
                o_result.valve_level  = i_entry.open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_elapsed <= '0;
            r_running <= 1'b0;
        end else if (i_accept) begin
            r_ptr     <= n_ptr;
            r_elapsed <= n_elapsed;
            r_running <= n_running;
        end
    end

endmodule

>>> src/tvss_out_reg.sv
// ----------------------------------------------------------------------------
// tvss_out_reg
// Result register of the master stream, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module tvss_out_reg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  tvss_pkg::t_result                i_result,
    output logic                             o_can_load,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [tvss_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic              r_valid;
    tvss_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = tvss_pkg::OUT_TDATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> tb/sv/tvss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_checker
// Watches both stream channels of the valve step sequencer. Every accepted
// input transfer is run through a local copy of the step table and run state
// to predict the result transfer, and every result transfer is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tvss_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [tvss_pkg::OPCODE_W-1:0]    i_s_tuser,
    input  logic [tvss_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [tvss_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_errors,
    output int                               o_pending
);

    logic [tvss_pkg::TARGET_W-1:0]   target_tbl [tvss_pkg::SEQ_STEPS];
    logic                            open_tbl   [tvss_pkg::SEQ_STEPS];
    logic [tvss_pkg::WAIT_W-1:0]     wait_tbl   [tvss_pkg::SEQ_STEPS];
    logic [tvss_pkg::CUR_STEP_W-1:0] step_ptr;
    logic [tvss_pkg::ELAPSED_W-1:0]  elapsed;
    logic                            armed;
    tvss_pkg::t_result               expected_actions [$];
    int                              error_count = 0;

    function automatic void run_current_step(inout tvss_pkg::t_result r);
        logic [tvss_pkg::TARGET_W-1:0] tgt;
        tgt     = target_tbl[step_ptr];
        elapsed = '0;
        if (tgt == tvss_pkg::TARGET_W'(tvss_pkg::NUM_VALVES)) begin
            r.start_other_arm = 1'b1;
        end else if (tgt < tvss_pkg::TARGET_W'(tvss_pkg::NUM_VALVES)) begin
            r.valve_write  = 1'b1;
            r.valve_number = tgt[tvss_pkg::VNUM_W-1:0];
            r.valve_level  = open_tbl[step_ptr];
        end
    endfunction

    function automatic void rewind(input logic demand, inout tvss_pkg::t_result r);
        step_ptr = '0;
        elapsed  = '0;
        armed    = demand;
        if (demand) begin
            run_current_step(r);
        end
    endfunction

    function automatic tvss_pkg::t_result sequencer_action(
        input logic [tvss_pkg::OPCODE_W-1:0]   op,
        input logic [tvss_pkg::IN_TDATA_W-1:0] d
    );
        tvss_pkg::t_result            r;
        logic                         demand;
        logic [tvss_pkg::INDEX_W-1:0] idx;
        r      = '0;
        demand = d[0];
        idx    = d[4:1];
        case (op)
            tvss_pkg::OP_TICK: begin
                if (armed) begin
                    if (elapsed != tvss_pkg::ELAPSED_MAX) begin
                        elapsed = elapsed + tvss_pkg::ELAPSED_W'(1);
                    end
                    if (elapsed > {1'b0, wait_tbl[step_ptr]}) begin
                        if (step_ptr == tvss_pkg::CUR_STEP_W'(tvss_pkg::SEQ_STEPS - 1)) begin
                            rewind(demand, r);
                        end else begin
                            step_ptr = step_ptr + tvss_pkg::CUR_STEP_W'(1);
                            run_current_step(r);
                        end
                    end
                end
            end
            tvss_pkg::OP_START: begin
                rewind(demand, r);
            end
            tvss_pkg::OP_LOAD: begin
                if (int'(idx) < tvss_pkg::SEQ_STEPS) begin
                    target_tbl[idx] = d[7:5];
                    open_tbl[idx]   = d[8];
                    wait_tbl[idx]   = d[24:9];
                end
            end
            default: begin
            end
        endcase
        r.arm_active   = armed;
        r.current_step = step_ptr;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        tvss_pkg::t_result got;
        tvss_pkg::t_result want;
        if (!i_rst_n) begin
            step_ptr = '0;
            elapsed  = '0;
            armed    = 1'b0;
            expected_actions.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = tvss_pkg::t_result'(i_m_tdata[$bits(tvss_pkg::t_result)-1:0]);
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_m_tdata);
                    error_count++;
                end else begin
                    want = expected_actions.pop_front();
                    check_field("valve_write", int'(want.valve_write),
                                int'(got.valve_write));
                    check_field("valve_number", int'(want.valve_number),
                                int'(got.valve_number));
                    check_field("valve_level", int'(want.valve_level),
                                int'(got.valve_level));
                    check_field("start_other_arm", int'(want.start_other_arm),
                                int'(got.start_other_arm));
                    check_field("arm_active", int'(want.arm_active),
                                int'(got.arm_active));
                    check_field("current_step", int'(want.current_step),
                                int'(got.current_step));
                    check_field("tdata padding", 0,
                                int'(i_m_tdata[tvss_pkg::OUT_TDATA_W-1:
                                               $bits(tvss_pkg::t_result)]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_actions.push_back(sequencer_action(i_s_tuser, i_s_tdata));
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_actions.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the timed valve step sequencer. Loads the whole
// step table, walks the directed corner cases, then streams random loads,
// starts, ticks and unused opcodes through phases of sender idling, receiver stalling and a
// long receiver hold-off, while the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [tvss_pkg::OPCODE_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                            CYCLE_LIMIT = 200000;
    localparam int                            PHASE_ITEMS = 120;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tvss_pkg::OPCODE_W-1:0]    s_axis_tuser  = tvss_pkg::OP_TICK;
    logic [tvss_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [tvss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int awaiting_count;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_len     = 0;
    int cycle_count  = 0;

    timed_valve_step_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tvss_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .o_errors   (mismatch_count),
        .o_pending  (awaiting_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // The receiver counts a requested hold-off itself, so the sender keeps offering.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                repeat (hold_len) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_len = 0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic logic [tvss_pkg::IN_TDATA_W-1:0] pack_fields(
        input logic                          demand,
        input logic [tvss_pkg::INDEX_W-1:0]  idx,
        input logic [tvss_pkg::TARGET_W-1:0] tgt,
        input logic                          opn,
        input logic [tvss_pkg::WAIT_W-1:0]   wt
    );
        return tvss_pkg::IN_TDATA_W'({wt, opn, tgt, idx, demand});
    endfunction

    task automatic offer(input logic [tvss_pkg::OPCODE_W-1:0]   op,
                         input logic [tvss_pkg::IN_TDATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic offer_random_item();
        int                            pick;
        logic [tvss_pkg::TARGET_W-1:0] tgt;
        logic [tvss_pkg::WAIT_W-1:0]   wt;
        logic                          demand;
        logic [tvss_pkg::INDEX_W-1:0]  idx;
        logic                          opn;
        pick   = $urandom_range(99);
        tgt    = ($urandom_range(3) == 0) ?
                 tvss_pkg::TARGET_W'($urandom_range(7)) :
                 tvss_pkg::TARGET_W'($urandom_range(tvss_pkg::NUM_VALVES));
        wt     = ($urandom_range(49) == 0) ? tvss_pkg::WAIT_W'($urandom) :
                 tvss_pkg::WAIT_W'($urandom_range(3));
        demand = ($urandom_range(3) != 0);
        idx    = tvss_pkg::INDEX_W'($urandom);
        opn    = 1'($urandom);
        if (pick < 15) begin
            offer(tvss_pkg::OP_LOAD, pack_fields(1'($urandom), idx, tgt, opn, wt));
        end else if (pick < 23) begin
            offer(tvss_pkg::OP_START,
                  pack_fields(demand, idx, tvss_pkg::TARGET_W'($urandom), opn,
                              tvss_pkg::WAIT_W'($urandom)));
        end else if (pick < 26) begin
            offer(OP_UNUSED,
                  pack_fields(1'($urandom), idx, tvss_pkg::TARGET_W'($urandom), opn,
                              tvss_pkg::WAIT_W'($urandom)));
        end else begin
            offer(tvss_pkg::OP_TICK,
                  pack_fields(demand, idx, tvss_pkg::TARGET_W'($urandom), opn,
                              tvss_pkg::WAIT_W'($urandom)));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before the table is loaded only commands that read no step are sent.
        offer(tvss_pkg::OP_TICK, pack_fields(1'b1, 4'hF, 3'd7, 1'b1, 16'hFFFF));
        offer(OP_UNUSED, pack_fields(1'b1, 4'hA, 3'd5, 1'b1, 16'h5A5A));
        for (int i = 0; i < tvss_pkg::SEQ_STEPS; i++) begin
            offer(tvss_pkg::OP_LOAD,
                  pack_fields(1'b0, tvss_pkg::INDEX_W'(i), tvss_pkg::TARGET_W'(i % 8),
                              (i >= 8),
                              (i == tvss_pkg::SEQ_STEPS - 1) ? 16'hFFFF :
                              tvss_pkg::WAIT_W'(i)));
        end
        offer(tvss_pkg::OP_START, pack_fields(1'b0, 4'h0, 3'd0, 1'b0, 16'h0000));
        offer(tvss_pkg::OP_START, pack_fields(1'b1, 4'h0, 3'd0, 1'b0, 16'h0000));
        offer(tvss_pkg::OP_TICK, pack_fields(1'b1, 4'h0, 3'd0, 1'b0, 16'h0000));
        offer(tvss_pkg::OP_TICK, pack_fields(1'b1, 4'h0, 3'd0, 1'b0, 16'h0000));
        offer(tvss_pkg::OP_TICK, pack_fields(1'b0, 4'h0, 3'd0, 1'b0, 16'h0000));
        offer(tvss_pkg::OP_LOAD, pack_fields(1'b0, 4'hF, 3'd4, 1'b1, 16'h0000));
        offer(tvss_pkg::OP_START, pack_fields(1'b1, 4'h0, 3'd0, 1'b0, 16'h0000));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 53;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 53;
                    hold_len     = 80;
                end
                default: begin
                    tx_idle_pct  = 19;
                    rx_stall_pct = 19;
                end
            endcase
            repeat (PHASE_ITEMS) offer_random_item();
        end

        s_axis_tvalid <= 1'b0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        while (awaiting_count != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaiting_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
